// ===== sv/wysm_pkg.sv =====
`timescale 1ns / 1ps
package wysm_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;

  localparam logic [63:0] NS_PER_HOUR = 64'd3600000000000;
  localparam logic [63:0] CALLS_SCALE = 64'd10000;

  localparam logic [47:0] SHORT_HORIZON_RST = 48'd600000000000;
  localparam logic [47:0] LONG_HORIZON_RST  = 48'd3600000000000;
  localparam logic [15:0] FLOOR_10K_RST     = 16'd25;
  localparam logic [31:0] FLOOR_HOUR_RST    = 32'd5000;
  localparam logic [7:0]  HYST_RST          = 8'd3;
  localparam logic [15:0] FIND_FLOOR_RST    = 16'd6;
  localparam logic [7:0]  TRUNC_RATIO_RST   = 8'd3;
  localparam logic [7:0]  THRU_DIV_RST      = 8'd2;

  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HORIZON = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HORIZON  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_10K     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_HOUR    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST          = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIND_FLOOR    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUNC_RATIO   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_THRU_DIV      = 4'd7;

  localparam logic [2:0] VETO_NONE    = 3'd0;
  localparam logic [2:0] VETO_STALLED = 3'd1;
  localparam logic [2:0] VETO_FINDING = 3'd2;
  localparam logic [2:0] VETO_TRUNC   = 3'd3;
  localparam logic [2:0] VETO_THRU    = 3'd4;

  typedef struct packed {
    logic [63:0] time_ns;
    logic [47:0] edges_total;
    logic [47:0] calls_total;
    logic [47:0] trunc_total;
    logic [47:0] findings_total;
    logic [15:0] stalled_count;
  } in_t;

  typedef struct packed {
    logic        sat_flag;
    logic [31:0] below_count;
    logic [2:0]  veto_reason;
    logic        short_valid;
    logic        long_valid;
    logic [63:0] short_window_ns;
    logic [47:0] short_edges_delta;
    logic [47:0] short_calls_delta;
    logic [63:0] long_window_ns;
    logic [47:0] long_edges_delta;
    logic [47:0] long_calls_delta;
  } out_t;

  typedef struct packed {
    logic [63:0] time_ns;
    logic [47:0] edges;
    logic [47:0] calls;
    logic [47:0] trunc;
    logic [47:0] findings;
  } ring_t;

  typedef struct packed {
    logic        found;
    logic [63:0] span;
    logic [47:0] de;
    logic [47:0] dc;
    logic [47:0] dt;
    logic [47:0] df;
  } win_t;

  typedef struct packed {
    logic [47:0] short_horizon;
    logic [47:0] long_horizon;
    logic [15:0] floor_10k;
    logic [31:0] floor_hour;
    logic [7:0]  hyst;
    logic [15:0] find_floor;
    logic [7:0]  trunc_ratio;
    logic [7:0]  thru_div;
  } cfg_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_res_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } cmp_op_t;

  function automatic logic [47:0] sat_sub48(input logic [47:0] x, input logic [47:0] y);
    sat_sub48 = (x > y) ? x - y : 48'd0;
  endfunction

endpackage

// ===== sv/wysm_ram.sv =====
`timescale 1ns / 1ps
module wysm_ram #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/wysm_pcmp.sv =====
`timescale 1ns / 1ps
module wysm_pcmp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  wysm_pkg::cmp_op_t    op_i,
  output logic                 done_o,
  output wysm_pkg::cmp_res_t   res_o
);

  logic                busy_q;
  logic                fin_q;
  logic                done_q;
  logic [2:0]          step_q;
  wysm_pkg::cmp_op_t   op_q;
  logic [127:0]        p1_q;
  logic [127:0]        p2_q;
  wysm_pkg::cmp_res_t  res_q;

  logic [63:0]  x;
  logic [63:0]  y;
  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    x  = step_q[2] ? op_q.c : op_q.a;
    y  = step_q[2] ? op_q.d : op_q.b;
    xs = step_q[0] ? x[63:32] : x[31:0];
    ys = step_q[1] ? y[63:32] : y[31:0];
    pp = 64'(xs) * 64'(ys);
    case (step_q[1:0])
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 3'd0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd7) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q <= op_i;
      p1_q <= '0;
      p2_q <= '0;
    end else if (busy_q) begin
      if (step_q[2]) begin
        p2_q <= p2_q + pp_sh;
      end else begin
        p1_q <= p1_q + pp_sh;
      end
    end
    if (fin_q) begin
      res_q.lt <= p1_q < p2_q;
      res_q.gt <= p1_q > p2_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== sv/windowed_yield_saturation_monitor.sv =====
`timescale 1ns / 1ps
// Each sample is written to a ring of RING_DEPTH entries, then the ring is walked back from
// the newest entry once for the short window and once for the long window, each entry read
// and then checked through the single read port of the ring memory; with fewer than two
// samples held, both windows are cleared without a walk. Seven exact 64x64 product compares
// follow on one shared 32x32 multiplier. One result is produced per sample; a finished
// result waits in an output register while the next sample is taken in.
module windowed_yield_saturation_monitor #(
  parameter int unsigned RING_DEPTH = wysm_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  wysm_pkg::in_t                      in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output wysm_pkg::out_t                     out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wysm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wysm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

  localparam logic WIN_S = 1'b0;
  localparam logic WIN_L = 1'b1;

  localparam logic [2:0] CMP_FIND  = 3'd0;
  localparam logic [2:0] CMP_TRUNC = 3'd1;
  localparam logic [2:0] CMP_THRU  = 3'd2;
  localparam logic [2:0] CMP_SCALL = 3'd3;
  localparam logic [2:0] CMP_SHOUR = 3'd4;
  localparam logic [2:0] CMP_LCALL = 3'd5;
  localparam logic [2:0] CMP_LHOUR = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_WINIT, S_RD, S_CHK, S_BASE, S_CGO, S_CWAIT, S_FIN
  } state_e;

  state_e              state_q;
  wysm_pkg::cfg_t      cfg_q;
  wysm_pkg::in_t       smp_q;
  logic [AW-1:0]       slot_q;
  logic [FW-1:0]       fill_q;
  logic [FW-1:0]       cnt_q;
  logic [AW-1:0]       ptr_q;
  logic [63:0]         cutoff_q;
  logic                win_sel_q;
  wysm_pkg::win_t      win_q [2];
  logic [2:0]          cmp_idx_q;
  logic [6:0]          flag_q;
  logic [31:0]         below_q;
  logic                out_valid_q;
  logic                out_valid_d;
  logic                out_load;
  wysm_pkg::out_t      out_q;

  wysm_pkg::ring_t     wr_data;
  wysm_pkg::ring_t     rd_data;
  logic [$bits(wysm_pkg::ring_t)-1:0] rd_raw;
  logic                in_xfer;

  logic [47:0]         hz;
  logic [63:0]         hz64;
  logic [63:0]         span;
  wysm_pkg::win_t      sw;
  wysm_pkg::win_t      lw;
  logic                sw_valid;
  logic                lw_valid;

  logic                cmp_start;
  wysm_pkg::cmp_op_t   cmp_op;
  logic                cmp_done;
  wysm_pkg::cmp_res_t  cmp_res;

  logic [2:0]          veto;
  logic                sb;
  logic                lb;
  logic [31:0]         below_d;
  wysm_pkg::out_t      out_d;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign out_load    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  assign wr_data.time_ns  = in_i.time_ns;
  assign wr_data.edges    = in_i.edges_total;
  assign wr_data.calls    = in_i.calls_total;
  assign wr_data.trunc    = in_i.trunc_total;
  assign wr_data.findings = in_i.findings_total;
  assign rd_data          = wysm_pkg::ring_t'(rd_raw);

  wysm_ram #(
    .WIDTH($bits(wysm_pkg::ring_t)),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (in_xfer),
    .waddr_i(slot_q),
    .wdata_i(wr_data),
    .raddr_i(ptr_q),
    .rdata_o(rd_raw)
  );

  assign sw       = win_q[WIN_S];
  assign lw       = win_q[WIN_L];
  assign sw_valid = (sw.span != 64'd0) && (sw.dc != 48'd0);
  assign lw_valid = (lw.span != 64'd0) && (lw.dc != 48'd0);

  always_comb begin
    hz   = win_sel_q ? cfg_q.long_horizon : cfg_q.short_horizon;
    hz64 = {16'd0, hz};
    span = (smp_q.time_ns > rd_data.time_ns) ? smp_q.time_ns - rd_data.time_ns : 64'd0;
  end

  assign cmp_start = (state_q == S_CGO);

  always_comb begin
    case (cmp_idx_q)
      CMP_FIND: begin
        cmp_op = '{a: {16'd0, sw.df}, b: wysm_pkg::NS_PER_HOUR,
                   c: {48'd0, cfg_q.find_floor}, d: sw.span};
      end
      CMP_TRUNC: begin
        cmp_op = '{a: {16'd0, sw.dt}, b: lw.span,
                   c: {8'd0, 56'(lw.dt) * 56'(cfg_q.trunc_ratio)}, d: sw.span};
      end
      CMP_THRU: begin
        cmp_op = '{a: {8'd0, 56'(sw.dc) * 56'(cfg_q.thru_div)}, b: lw.span,
                   c: {16'd0, lw.dc}, d: sw.span};
      end
      CMP_SCALL: begin
        cmp_op = '{a: {16'd0, sw.de}, b: wysm_pkg::CALLS_SCALE,
                   c: {48'd0, cfg_q.floor_10k}, d: {16'd0, sw.dc}};
      end
      CMP_SHOUR: begin
        cmp_op = '{a: {16'd0, sw.de}, b: wysm_pkg::NS_PER_HOUR,
                   c: {32'd0, cfg_q.floor_hour}, d: sw.span};
      end
      CMP_LCALL: begin
        cmp_op = '{a: {16'd0, lw.de}, b: wysm_pkg::CALLS_SCALE,
                   c: {48'd0, cfg_q.floor_10k}, d: {16'd0, lw.dc}};
      end
      default: begin
        cmp_op = '{a: {16'd0, lw.de}, b: wysm_pkg::NS_PER_HOUR,
                   c: {32'd0, cfg_q.floor_hour}, d: lw.span};
      end
    endcase
  end

  wysm_pcmp u_pcmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmp_start),
    .op_i   (cmp_op),
    .done_o (cmp_done),
    .res_o  (cmp_res)
  );

  always_comb begin
    veto = wysm_pkg::VETO_NONE;
    if (smp_q.stalled_count != 16'd0) begin
      veto = wysm_pkg::VETO_STALLED;
    end else if (sw.found && ((sw.span == 64'd0) ? (cfg_q.find_floor == 16'd0)
                                                 : flag_q[CMP_FIND])) begin
      veto = wysm_pkg::VETO_FINDING;
    end else if ((sw.span != 64'd0) && (lw.span != 64'd0) && lw.found &&
                 (lw.dt != 48'd0) && flag_q[CMP_TRUNC]) begin
      veto = wysm_pkg::VETO_TRUNC;
    end
    if ((veto == wysm_pkg::VETO_NONE) && sw_valid && lw_valid && flag_q[CMP_THRU]) begin
      veto = wysm_pkg::VETO_THRU;
    end
    sb = sw_valid && (flag_q[CMP_SCALL] || flag_q[CMP_SHOUR]);
    lb = lw_valid && (flag_q[CMP_LCALL] || flag_q[CMP_LHOUR]);
    if (sb && lb && (veto == wysm_pkg::VETO_NONE)) begin
      below_d = (below_q != 32'hFFFF_FFFF) ? below_q + 32'd1 : below_q;
    end else begin
      below_d = 32'd0;
    end
    out_d.sat_flag          = (below_d >= {24'd0, cfg_q.hyst});
    out_d.below_count       = below_d;
    out_d.veto_reason       = veto;
    out_d.short_valid       = sw_valid;
    out_d.long_valid        = lw_valid;
    out_d.short_window_ns   = sw.span;
    out_d.short_edges_delta = sw.de;
    out_d.short_calls_delta = sw.dc;
    out_d.long_window_ns    = lw.span;
    out_d.long_edges_delta  = lw.de;
    out_d.long_calls_delta  = lw.dc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_horizon <= wysm_pkg::SHORT_HORIZON_RST;
      cfg_q.long_horizon  <= wysm_pkg::LONG_HORIZON_RST;
      cfg_q.floor_10k     <= wysm_pkg::FLOOR_10K_RST;
      cfg_q.floor_hour    <= wysm_pkg::FLOOR_HOUR_RST;
      cfg_q.hyst          <= wysm_pkg::HYST_RST;
      cfg_q.find_floor    <= wysm_pkg::FIND_FLOOR_RST;
      cfg_q.trunc_ratio   <= wysm_pkg::TRUNC_RATIO_RST;
      cfg_q.thru_div      <= wysm_pkg::THRU_DIV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        wysm_pkg::CFG_SHORT_HORIZON: cfg_q.short_horizon <= cfg_data_i;
        wysm_pkg::CFG_LONG_HORIZON:  cfg_q.long_horizon  <= cfg_data_i;
        wysm_pkg::CFG_FLOOR_10K:     cfg_q.floor_10k     <= cfg_data_i[15:0];
        wysm_pkg::CFG_FLOOR_HOUR:    cfg_q.floor_hour    <= cfg_data_i[31:0];
        wysm_pkg::CFG_HYST:          cfg_q.hyst          <= cfg_data_i[7:0];
        wysm_pkg::CFG_FIND_FLOOR:    cfg_q.find_floor    <= cfg_data_i[15:0];
        wysm_pkg::CFG_TRUNC_RATIO:   cfg_q.trunc_ratio   <= cfg_data_i[7:0];
        wysm_pkg::CFG_THRU_DIV:      cfg_q.thru_div      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      fill_q      <= '0;
      below_q     <= 32'd0;
      out_valid_q <= 1'b0;
      win_sel_q   <= WIN_S;
      cmp_idx_q   <= CMP_FIND;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            smp_q     <= in_i;
            slot_q    <= (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
            fill_q    <= (fill_q != FW'(RING_DEPTH)) ? fill_q + FW'(1) : fill_q;
            win_sel_q <= WIN_S;
            state_q   <= S_WINIT;
          end
        end
        S_WINIT: begin
          if (fill_q < FW'(2)) begin
            win_q[win_sel_q] <= '0;
            if (win_sel_q == WIN_L) begin
              cmp_idx_q <= CMP_FIND;
              state_q   <= S_CGO;
            end else begin
              win_sel_q <= WIN_L;
            end
          end else begin
            cutoff_q <= (smp_q.time_ns > hz64) ? smp_q.time_ns - hz64 : 64'd0;
            cnt_q    <= FW'(1);
            ptr_q    <= (slot_q == '0) ? LAST_SLOT : slot_q - AW'(1);
            state_q  <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_CHK;
        end
        S_CHK: begin
          if ((rd_data.time_ns <= cutoff_q) || (cnt_q == fill_q)) begin
            state_q <= S_BASE;
          end else begin
            cnt_q   <= cnt_q + FW'(1);
            ptr_q   <= (ptr_q == '0) ? LAST_SLOT : ptr_q - AW'(1);
            state_q <= S_RD;
          end
        end
        S_BASE: begin
          if (span < (hz64 >> 1)) begin
            win_q[win_sel_q] <= '0;
          end else begin
            win_q[win_sel_q].found <= 1'b1;
            win_q[win_sel_q].span  <= span;
            win_q[win_sel_q].de <= wysm_pkg::sat_sub48(smp_q.edges_total, rd_data.edges);
            win_q[win_sel_q].dc <= wysm_pkg::sat_sub48(smp_q.calls_total, rd_data.calls);
            win_q[win_sel_q].dt <= wysm_pkg::sat_sub48(smp_q.trunc_total, rd_data.trunc);
            win_q[win_sel_q].df <= wysm_pkg::sat_sub48(smp_q.findings_total,
                                                       rd_data.findings);
          end
          if (win_sel_q == WIN_L) begin
            cmp_idx_q <= CMP_FIND;
            state_q   <= S_CGO;
          end else begin
            win_sel_q <= WIN_L;
            state_q   <= S_WINIT;
          end
        end
        S_CGO: begin
          state_q <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cmp_done) begin
            case (cmp_idx_q)
              CMP_FIND:  flag_q[cmp_idx_q] <= !cmp_res.lt;
              CMP_TRUNC: flag_q[cmp_idx_q] <= cmp_res.gt;
              default:   flag_q[cmp_idx_q] <= cmp_res.lt;
            endcase
            if (cmp_idx_q == CMP_LHOUR) begin
              state_q <= S_FIN;
            end else begin
              cmp_idx_q <= cmp_idx_q + 3'd1;
              state_q   <= S_CGO;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_q   <= out_d;
            below_q <= below_d;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(RING_DEPTH))
    else $error("fill count past ring depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.veto_reason <= wysm_pkg::VETO_THRU))
    else $error("veto reason out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.sat_flag == (out_o.below_count >= {24'd0, cfg_q.hyst})))
    else $error("saturated flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.short_valid) |->
      (out_o.short_window_ns != 64'd0) && (out_o.short_calls_delta != 48'd0))
    else $error("short window valid with empty deltas");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_WINIT))
    else $error("transfer did not start a walk");

endmodule
